// ----- src/kst_pkg.sv -----
// Shared types and codes for the keyed slot table.
`timescale 1ns / 1ps

package kst_pkg;

   // Request operation codes.
   typedef enum logic [1:0] {
      OP_CLAIM   = 2'd0,
      OP_LOOKUP  = 2'd1,
      OP_PEEK    = 2'd2,
      OP_RELEASE = 2'd3
   } opcode_type;

   // Response status codes.
   typedef enum logic [1:0] {
      STAT_HIT   = 2'd0,
      STAT_FREE  = 2'd1,
      STAT_EVICT = 2'd2,
      STAT_MISS  = 2'd3
   } status_type;

   // Width of the key and of the use stamps.
   localparam int KEY_W   = 64;
   localparam int STAMP_W = 64;
   localparam int SLOT_W  = 3;

   // Result of one pass through the shared compare unit.
   typedef struct packed {
      logic key_eq;
      logic stamp_lt;
   } cmp_res_type;

endpackage

// ----- src/kst_cmp.sv -----
// Shared compare unit: key equality and stamp ordering for one slot.
`timescale 1ns / 1ps

module kst_cmp import kst_pkg::*; (
   input  logic [KEY_W-1:0]   key_a,
   input  logic [KEY_W-1:0]   key_b,
   input  logic [STAMP_W-1:0] stamp_a,
   input  logic [STAMP_W-1:0] stamp_b,
   output cmp_res_type        result
);

   // One wide equality and one wide magnitude compare.
   always_comb begin
      result.key_eq   = (key_a == key_b);
      result.stamp_lt = (stamp_a < stamp_b);
   end

endmodule

// ----- src/keyed_slot_table_lru_evict.sv -----
// Top level of the fully associative keyed slot table with LRU eviction.
`timescale 1ns / 1ps

// The table holds ENTRIES slots, each with a 64-bit key, a valid mark and a
// 64-bit use stamp. Each request (claim, lookup, peek or release) is scanned
// against the slots one slot per cycle through a single memory read port and
// one shared compare unit, which finds the matching slot, the first free slot
// and the least recently used slot in the same pass. The scan is followed by
// the drain and decide states, after which the result is held until it is
// taken. The block takes no new item while one is in work, and it accepts the
// next item in the cycle after the result is taken. req_stall stays high while
// an item is in work. No clearing pass is needed after reset.
module keyed_slot_table_lru_evict import kst_pkg::*; #(
   parameter int ENTRIES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_opcode,
   input  logic [KEY_W-1:0]  req_key,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [SLOT_W-1:0] rsp_slot_index
);

   localparam int IDX_W = $clog2(ENTRIES);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DECIDE,
      S_RESP
   } state_type;

   state_type           state_ff;
   opcode_type          op_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [IDX_W-1:0]    rd_addr_ff;
   logic [IDX_W-1:0]    cmp_idx_ff;
   logic                cmp_vld_ff;
   logic [KEY_W-1:0]    key_rd_ff;
   logic [STAMP_W-1:0]  stamp_rd_ff;
   logic                found_ff;
   logic [IDX_W-1:0]    found_idx_ff;
   logic                free_ff;
   logic [IDX_W-1:0]    free_idx_ff;
   logic [IDX_W-1:0]    best_idx_ff;
   logic [STAMP_W-1:0]  best_stamp_ff;
   logic [ENTRIES-1:0]  valid_ff;
   logic [STAMP_W-1:0]  use_tick_ff;
   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;

   logic [KEY_W-1:0]    key_mem   [ENTRIES];
   logic [STAMP_W-1:0]  stamp_mem [ENTRIES];

   cmp_res_type         cmp_res;
   status_type          status_in;
   logic [IDX_W-1:0]    pick_in;
   logic [IDX_W+2:0]    pick_ext;
   logic [STAMP_W-1:0]  tick_in;
   logic                key_wr_raw;
   logic                stamp_wr_raw;
   logic                rel_raw;
   logic                key_wr;
   logic                stamp_wr;
   logic                rel;
   logic                is_decide;
   logic                req_take;

   assign req_stall      = (state_ff != S_IDLE);
   assign req_take       = req_valid && !req_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;

   // Shared compare unit, fed from the registered memory read data.
   kst_cmp u_cmp (
      .key_a   (key_rd_ff),
      .key_b   (key_ff),
      .stamp_a (stamp_rd_ff),
      .stamp_b (best_stamp_ff),
      .result  (cmp_res)
   );

   // Choose the slot and status once the scan has finished.
   always_comb begin
      status_in    = STAT_MISS;
      pick_in      = '0;
      key_wr_raw   = 1'b0;
      stamp_wr_raw = 1'b0;
      rel_raw      = 1'b0;
      case (op_ff)
         OP_CLAIM: begin
            key_wr_raw   = 1'b1;
            stamp_wr_raw = 1'b1;
            if (found_ff) begin
               status_in = STAT_HIT;
               pick_in   = found_idx_ff;
            end else if (free_ff) begin
               status_in = STAT_FREE;
               pick_in   = free_idx_ff;
            end else begin
               status_in = STAT_EVICT;
               pick_in   = best_idx_ff;
            end
         end
         OP_LOOKUP: begin
            if (found_ff) begin
               status_in    = STAT_HIT;
               pick_in      = found_idx_ff;
               stamp_wr_raw = 1'b1;
            end
         end
         OP_PEEK: begin
            if (found_ff) begin
               status_in = STAT_HIT;
               pick_in   = found_idx_ff;
            end
         end
         OP_RELEASE: begin
            if (found_ff) begin
               status_in = STAT_HIT;
               pick_in   = found_idx_ff;
               rel_raw   = 1'b1;
            end
         end
         default: begin
            status_in = STAT_MISS;
         end
      endcase
   end

   assign is_decide = (state_ff == S_DECIDE);
   assign key_wr    = is_decide && key_wr_raw;
   assign stamp_wr  = is_decide && stamp_wr_raw;
   assign rel       = is_decide && rel_raw;
   assign tick_in   = use_tick_ff + STAMP_W'(1);
   assign pick_ext  = {3'b000, pick_in};

   // Key and stamp memories: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (key_wr) begin
         key_mem[pick_in] <= key_ff;
      end
      if (stamp_wr) begin
         stamp_mem[pick_in] <= tick_in;
      end
      key_rd_ff   <= key_mem[rd_addr_ff];
      stamp_rd_ff <= stamp_mem[rd_addr_ff];
   end

   // Sequencer: scan the slots, decide, update the table and hold the result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cmp_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         use_tick_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         rd_addr_ff   <= '0;
      end else begin
         cmp_vld_ff <= (state_ff == S_SCAN);
         cmp_idx_ff <= rd_addr_ff;

         // Fold one slot into the running match, free and oldest picks.
         if (cmp_vld_ff) begin
            if (valid_ff[cmp_idx_ff]) begin
               if (cmp_res.key_eq && !found_ff) begin
                  found_ff     <= 1'b1;
                  found_idx_ff <= cmp_idx_ff;
               end
            end else if (!free_ff) begin
               free_ff     <= 1'b1;
               free_idx_ff <= cmp_idx_ff;
            end
            if (cmp_idx_ff == '0 || cmp_res.stamp_lt) begin
               best_idx_ff   <= cmp_idx_ff;
               best_stamp_ff <= stamp_rd_ff;
            end
         end

         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  op_ff      <= opcode_type'(req_opcode);
                  key_ff     <= req_key;
                  rd_addr_ff <= '0;
                  found_ff   <= 1'b0;
                  free_ff    <= 1'b0;
                  state_ff   <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (rd_addr_ff == IDX_W'(ENTRIES - 1)) begin
                  state_ff <= S_DRAIN;
               end else begin
                  rd_addr_ff <= rd_addr_ff + IDX_W'(1);
               end
            end
            S_DRAIN: begin
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               if (key_wr) begin
                  valid_ff[pick_in] <= 1'b1;
               end
               if (rel) begin
                  valid_ff[pick_in] <= 1'b0;
               end
               if (stamp_wr) begin
                  use_tick_ff <= tick_in;
               end
               rsp_valid_ff  <= 1'b1;
               rsp_status_ff <= status_in;
               rsp_slot_ff   <= pick_ext[2:0];
               state_ff      <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // A new item is never taken while a result is still offered.
   assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("request accepted while a result is pending");

   // A miss always reports slot zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_MISS) |-> (rsp_slot_index == '0))
      else $error("miss reported with a nonzero slot");

   // Every accepted item has its result ready once the scan, drain and decide states have passed.
   assert property (@(posedge clock) disable iff (reset)
      req_take |-> ##(ENTRIES + 3) rsp_valid)
      else $error("result not ready after the scan latency");

   // The use tick only holds or advances by one.
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (use_tick_ff == $past(use_tick_ff) ||
                use_tick_ff == $past(use_tick_ff) + STAMP_W'(1)))
      else $error("use tick moved by more than one");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the keyed slot table with LRU eviction.
`timescale 1ns / 1ps

module testbench import kst_pkg::*; ();

   localparam int SLOTS       = 8;
   localparam int RANDOM_REQS = 700;
   localparam int POOL_SIZE   = 12;
   localparam int IDLE_PCT    = 36;
   localparam int QUIET_FROM  = 4000;
   localparam int QUIET_TO    = 7000;
   localparam int HOLD_AFTER  = 150;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_WAIT  = SLOTS + 8;

   typedef struct {
      opcode_type       op;
      logic [KEY_W-1:0] key;
   } table_req_type;

   typedef struct {
      status_type        status;
      logic [SLOT_W-1:0] slot;
   } table_reply_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_opcode = OP_PEEK;
   logic [KEY_W-1:0]    req_key = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_status;
   logic [SLOT_W-1:0]   rsp_slot_index;

   table_req_type   request_queue[$];
   table_reply_type pending_replies[$];

   // Shadow copy of the table used to predict each reply.
   logic [KEY_W-1:0]   shadow_key[SLOTS];
   bit                 shadow_live[SLOTS];
   logic [STAMP_W-1:0] shadow_stamp[SLOTS];
   logic [STAMP_W-1:0] shadow_tick = '0;

   int total_reqs = 0;
   int reqs_taken = 0;
   int replies_taken = 0;
   int error_count = 0;
   int cycle_count = 0;
   int dry_cycles = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   keyed_slot_table_lru_evict #(
      .ENTRIES(SLOTS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_key(req_key),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_slot_index(rsp_slot_index)
   );

   // Free-running clock, 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Apply one request to the shadow table and return the reply it should produce.
   function automatic table_reply_type apply_table_op(opcode_type op, logic [KEY_W-1:0] key);
      table_reply_type r;
      int found;
      int pick;
      found = -1;
      pick = 0;
      r.status = STAT_MISS;
      for (int i = 0; i < SLOTS; i++)
         if (found < 0 && shadow_live[i] && shadow_key[i] == key)
            found = i;
      if (op == OP_CLAIM) begin
         if (found >= 0) begin
            r.status = STAT_HIT;
            pick = found;
         end else begin
            int free_slot;
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++)
               if (free_slot < 0 && !shadow_live[i])
                  free_slot = i;
            if (free_slot >= 0) begin
               r.status = STAT_FREE;
               pick = free_slot;
            end else begin
               // Oldest stamp loses its slot; the lowest index wins a tie.
               r.status = STAT_EVICT;
               for (int i = 1; i < SLOTS; i++)
                  if (shadow_stamp[i] < shadow_stamp[pick])
                     pick = i;
            end
         end
         shadow_key[pick] = key;
         shadow_live[pick] = 1'b1;
         shadow_tick = shadow_tick + STAMP_W'(1);
         shadow_stamp[pick] = shadow_tick;
      end else if (found >= 0) begin
         r.status = STAT_HIT;
         pick = found;
         if (op == OP_LOOKUP) begin
            shadow_tick = shadow_tick + STAMP_W'(1);
            shadow_stamp[pick] = shadow_tick;
         end else if (op == OP_RELEASE) begin
            shadow_live[pick] = 1'b0;
         end
      end
      r.slot = SLOT_W'(pick);
      return r;
   endfunction

   function automatic logic [KEY_W-1:0] random_key();
      return {$urandom(), $urandom()};
   endfunction

   function automatic void queue_req(opcode_type op, logic [KEY_W-1:0] key);
      table_req_type t;
      t.op = op;
      t.key = key;
      request_queue.push_back(t);
   endfunction

   // Cycle counter and watchdog on the accepted traffic.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         dry_cycles <= 0;
      end else if (dry_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         dry_cycles <= dry_cycles + 1;
      end
   end

   // Request driver: predicts each accepted item, then offers the next one.
   always @(posedge clock) begin
      table_req_type t;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_replies.push_back(apply_table_op(opcode_type'(req_opcode), req_key));
            reqs_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (request_queue.size() > 0 &&
                ((cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) ||
                 $urandom_range(0, 99) >= IDLE_PCT)) begin
               t = request_queue.pop_front();
               req_valid <= 1'b1;
               req_opcode <= t.op;
               req_key <= t.key;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Reply monitor: checks each accepted item and drives the stall.
   always @(posedge clock) begin
      table_reply_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            replies_taken++;
            if (pending_replies.size() == 0) begin
               $error("reply with nothing pending: status %0d slot_index %0d",
                      rsp_status, rsp_slot_index);
               error_count++;
            end else begin
               e = pending_replies.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status mismatch: expected %0d, got %0d", e.status, rsp_status);
                  error_count++;
               end
               if (rsp_slot_index !== e.slot) begin
                  $error("slot_index mismatch: expected %0d, got %0d",
                         e.slot, rsp_slot_index);
                  error_count++;
               end
            end
         end
         // One long hold-off so that the block backs up into the sender.
         if (replies_taken >= HOLD_AFTER && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      logic [KEY_W-1:0] pool[POOL_SIZE];
      logic [KEY_W-1:0] k;
      int roll;

      for (int i = 0; i < SLOTS; i++) begin
         shadow_key[i] = '0;
         shadow_live[i] = 1'b0;
         shadow_stamp[i] = '0;
      end

      // Directed: empty table, fill, hits, eviction, misses and release.
      queue_req(OP_PEEK, 64'h0);
      queue_req(OP_CLAIM, 64'h0);
      queue_req(OP_CLAIM, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_req(OP_CLAIM, 64'h8000_0000_0000_0000);
      queue_req(OP_CLAIM, 64'h0000_0000_0000_0001);
      queue_req(OP_CLAIM, 64'h5555_5555_5555_5555);
      queue_req(OP_CLAIM, 64'hAAAA_AAAA_AAAA_AAAA);
      queue_req(OP_CLAIM, 64'h0123_4567_89AB_CDEF);
      queue_req(OP_CLAIM, 64'hFEDC_BA98_7654_3210);
      queue_req(OP_CLAIM, 64'h0);
      queue_req(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_req(OP_PEEK, 64'h8000_0000_0000_0000);
      queue_req(OP_CLAIM, 64'hDEAD_BEEF_0000_0001);
      queue_req(OP_LOOKUP, 64'h8000_0000_0000_0000);
      queue_req(OP_RELEASE, 64'h5555_5555_5555_5555);
      queue_req(OP_RELEASE, 64'h5555_5555_5555_5555);
      queue_req(OP_PEEK, 64'h5555_5555_5555_5555);
      queue_req(OP_CLAIM, 64'h5555_0000_0000_5555);
      queue_req(OP_CLAIM, 64'h7FFF_FFFF_FFFF_FFFE);
      queue_req(OP_LOOKUP, 64'h0);
      queue_req(OP_RELEASE, 64'h0);
      queue_req(OP_CLAIM, 64'h0);
      queue_req(OP_CLAIM, 64'h0000_0000_0000_0001);

      // Random: mostly keys from a small pool so that hits and evictions are common.
      for (int i = 0; i < POOL_SIZE; i++)
         pool[i] = random_key();
      for (int n = 0; n < RANDOM_REQS; n++) begin
         if ($urandom_range(0, 99) < 10)
            pool[$urandom_range(0, POOL_SIZE - 1)] = random_key();
         if ($urandom_range(0, 99) < 85)
            k = pool[$urandom_range(0, POOL_SIZE - 1)];
         else
            k = random_key();
         roll = $urandom_range(0, 99);
         if (roll < 35)
            queue_req(OP_CLAIM, k);
         else if (roll < 60)
            queue_req(OP_LOOKUP, k);
         else if (roll < 80)
            queue_req(OP_PEEK, k);
         else
            queue_req(OP_RELEASE, k);
      end
      total_reqs = request_queue.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (reqs_taken == total_reqs);
      wait (replies_taken == total_reqs);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/kst_pkg.sv
src/kst_cmp.sv
src/keyed_slot_table_lru_evict.sv
verif/testbench.sv
